// ===== hw/rtl/dnsc_pkg.sv =====
// Shared types and constants for the DNS name syntax checker.
`timescale 1ns / 1ps
package dnsc_pkg;

  localparam int FlagW  = 10;
  localparam int CountW = 8;
  localparam int NameW  = 9;
  localparam int LabelW = 8;

  localparam logic [FlagW-1:0] F_EMPTY      = 10'h001;
  localparam logic [FlagW-1:0] F_TOO_LONG   = 10'h002;
  localparam logic [FlagW-1:0] F_NOT_ROOTED = 10'h004;
  localparam logic [FlagW-1:0] F_LABEL_LONG = 10'h008;
  localparam logic [FlagW-1:0] F_BLANK      = 10'h010;
  localparam logic [FlagW-1:0] F_LEAD_HYPH  = 10'h020;
  localparam logic [FlagW-1:0] F_TRAIL_HYPH = 10'h040;
  localparam logic [FlagW-1:0] F_STAR       = 10'h080;
  localparam logic [FlagW-1:0] F_ILLEGAL    = 10'h100;
  localparam logic [FlagW-1:0] F_WILDCARD   = 10'h200;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [1:0] REG_RECORD_MODE = 2'd0;
  localparam logic [1:0] REG_ALLOW_UNDER = 2'd1;
  localparam logic [1:0] REG_MAX_NAME    = 2'd2;
  localparam logic [1:0] REG_MAX_LABEL   = 2'd3;

  typedef struct packed {
    logic has_char;
    logic last;
    logic is_dot;
    logic is_hyphen;
    logic is_star;
    logic is_under;
    logic is_alnum;
  } dnsc_char_t;

  typedef struct packed {
    logic       record_name_mode;
    logic       underscore_ok;
    logic [7:0] max_name_length;
    logic [5:0] max_label_length;
  } dnsc_cfg_t;

endpackage

// ===== hw/rtl/dnsc_front.sv =====
// Front stage: takes character beats and registers their classification.
`timescale 1ns / 1ps
module dnsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic                has_char,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output dnsc_pkg::dnsc_char_t out_char
);
  import dnsc_pkg::*;

  dnsc_char_t cls;

  always_comb begin
    cls.has_char  = has_char;
    cls.last      = last;
    cls.is_dot    = (char_code == CH_DOT);
    cls.is_hyphen = (char_code == CH_HYPHEN);
    cls.is_star   = (char_code == CH_STAR);
    cls.is_under  = (char_code == CH_UNDER);
    cls.is_alnum  = (char_code >= 8'h30 && char_code <= 8'h39) ||
                    (char_code >= 8'h41 && char_code <= 8'h5A) ||
                    (char_code >= 8'h61 && char_code <= 8'h7A);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_char <= cls;
    end
  end

endmodule

// ===== hw/rtl/dnsc_queue.sv =====
// Small FIFO of classified characters between front and back.
`timescale 1ns / 1ps
module dnsc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dnsc_pkg::dnsc_char_t push_data,
  output logic                full,
  input  logic                pop,
  output dnsc_pkg::dnsc_char_t pop_data,
  output logic                empty
);
  import dnsc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  dnsc_char_t        mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full     = (count == DepthC);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/dnsc_back.sv =====
// Back stage: label and name state, result assembly and output register.
`timescale 1ns / 1ps
module dnsc_back (
  input  logic                clk,
  input  logic                rst,
  input  dnsc_pkg::dnsc_cfg_t cfg,
  input  logic                q_empty,
  input  dnsc_pkg::dnsc_char_t q_data,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [9:0]          res_flags,
  output logic [7:0]          res_count
);
  import dnsc_pkg::*;

  logic [NameW-1:0]  name_length, nl_n, name_length_next;
  logic [LabelW-1:0] label_length, ll_n, label_length_next;
  logic              previous_was_hyphen, pwh_n, previous_was_hyphen_next;
  logic              label_is_star, lis_n, label_is_star_next;
  logic              first_was_dot, fwd_n, first_was_dot_next;
  logic [FlagW-1:0]  pending_flags, pf_n, pending_flags_next;
  logic [CountW-1:0] pending_count, pc_n, pending_count_next;
  logic [FlagW-1:0]  committed_flags, cf_n, committed_flags_next;
  logic [CountW-1:0] committed_count, cc_n, committed_count_next;

  logic              finish;
  logic [FlagW-1:0]  fin_flags;
  logic [CountW-1:0] fin_count;
  logic [FlagW-1:0]  add_flags;
  logic [1:0]        add_n;
  logic [CountW:0]   pc_sum, cc_sum, nr_sum;
  logic [CountW-1:0] pc_close;
  logic              wild, bad, star_hit, ill_hit, lead;

  assign q_pop  = !q_empty && (!res_valid || res_ready);
  assign finish = !q_data.has_char || q_data.last;

  always_comb begin
    nl_n     = name_length;
    ll_n     = label_length;
    pwh_n    = previous_was_hyphen;
    lis_n    = label_is_star;
    fwd_n    = first_was_dot;
    pf_n     = pending_flags;
    pc_n     = pending_count;
    cf_n     = committed_flags;
    cc_n     = committed_count;
    add_flags = '0;
    add_n    = '0;
    pc_sum   = '0;
    cc_sum   = '0;
    pc_close = pending_count;
    wild     = (label_length == LabelW'(1)) && label_is_star;
    lead     = (label_length == '0) && q_data.is_hyphen;
    bad      = !q_data.is_alnum && !q_data.is_hyphen;
    star_hit = bad && cfg.record_name_mode && q_data.is_star;
    ill_hit  = bad && !(cfg.record_name_mode && q_data.is_star) &&
               !(q_data.is_under && cfg.underscore_ok);
    if (q_data.has_char) begin
      if (name_length == '0) begin
        fwd_n = q_data.is_dot;
      end
      if (name_length != '1) begin
        nl_n = name_length + NameW'(1);
      end
      if (q_data.is_dot) begin
        if (wild) begin
          if (!cfg.record_name_mode) begin
            cf_n   = committed_flags | F_WILDCARD;
            cc_sum = {1'b0, committed_count} + (CountW+1)'(1);
            cc_n   = cc_sum[CountW] ? '1 : cc_sum[CountW-1:0];
          end
        end else begin
          if (label_length > {2'b00, cfg.max_label_length}) begin
            add_flags = add_flags | F_LABEL_LONG;
            add_n     = add_n + 2'd1;
          end
          if (label_length == '0) begin
            add_flags = add_flags | F_BLANK;
            add_n     = add_n + 2'd1;
          end
          if (label_length != '0 && previous_was_hyphen) begin
            add_flags = add_flags | F_TRAIL_HYPH;
            add_n     = add_n + 2'd1;
          end
          pc_sum   = {1'b0, pending_count} + (CountW+1)'(add_n);
          pc_close = pc_sum[CountW] ? '1 : pc_sum[CountW-1:0];
          cf_n     = committed_flags | pending_flags | add_flags;
          cc_sum   = {1'b0, committed_count} + {1'b0, pc_close};
          cc_n     = cc_sum[CountW] ? '1 : cc_sum[CountW-1:0];
        end
        pf_n  = '0;
        pc_n  = '0;
        ll_n  = '0;
        pwh_n = 1'b0;
        lis_n = 1'b0;
      end else begin
        if (label_length == '0) begin
          lis_n = q_data.is_star;
        end
        if (lead) begin
          add_flags = add_flags | F_LEAD_HYPH;
          add_n     = add_n + 2'd1;
        end
        if (star_hit) begin
          add_flags = add_flags | F_STAR;
          add_n     = add_n + 2'd1;
        end
        if (ill_hit) begin
          add_flags = add_flags | F_ILLEGAL;
          add_n     = add_n + 2'd1;
        end
        pf_n   = pending_flags | add_flags;
        pc_sum = {1'b0, pending_count} + (CountW+1)'(add_n);
        pc_n   = pc_sum[CountW] ? '1 : pc_sum[CountW-1:0];
        pwh_n  = q_data.is_hyphen;
        if (label_length != '1) begin
          ll_n = label_length + LabelW'(1);
        end
      end
    end
  end

  always_comb begin
    nr_sum = {1'b0, cc_n} + (CountW+1)'(1);
    if (nl_n == '0) begin
      fin_flags = F_EMPTY;
      fin_count = CountW'(1);
    end else if (nl_n > {1'b0, cfg.max_name_length}) begin
      fin_flags = F_TOO_LONG;
      fin_count = CountW'(1);
    end else if (nl_n == NameW'(1) && fwd_n) begin
      fin_flags = '0;
      fin_count = '0;
    end else if (ll_n != '0) begin
      fin_flags = cf_n | F_NOT_ROOTED;
      fin_count = nr_sum[CountW] ? '1 : nr_sum[CountW-1:0];
    end else begin
      fin_flags = cf_n;
      fin_count = cc_n;
    end
  end

  always_comb begin
    name_length_next         = name_length;
    label_length_next        = label_length;
    previous_was_hyphen_next = previous_was_hyphen;
    label_is_star_next       = label_is_star;
    first_was_dot_next       = first_was_dot;
    pending_flags_next       = pending_flags;
    pending_count_next       = pending_count;
    committed_flags_next     = committed_flags;
    committed_count_next     = committed_count;
    if (q_pop) begin
      if (finish) begin
        name_length_next         = '0;
        label_length_next        = '0;
        previous_was_hyphen_next = 1'b0;
        label_is_star_next       = 1'b0;
        first_was_dot_next       = 1'b0;
        pending_flags_next       = '0;
        pending_count_next       = '0;
        committed_flags_next     = '0;
        committed_count_next     = '0;
      end else begin
        name_length_next         = nl_n;
        label_length_next        = ll_n;
        previous_was_hyphen_next = pwh_n;
        label_is_star_next       = lis_n;
        first_was_dot_next       = fwd_n;
        pending_flags_next       = pf_n;
        pending_count_next       = pc_n;
        committed_flags_next     = cf_n;
        committed_count_next     = cc_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length         <= '0;
      label_length        <= '0;
      previous_was_hyphen <= 1'b0;
      label_is_star       <= 1'b0;
      first_was_dot       <= 1'b0;
      pending_flags       <= '0;
      pending_count       <= '0;
      committed_flags     <= '0;
      committed_count     <= '0;
      res_valid           <= 1'b0;
    end else begin
      name_length         <= name_length_next;
      label_length        <= label_length_next;
      previous_was_hyphen <= previous_was_hyphen_next;
      label_is_star       <= label_is_star_next;
      first_was_dot       <= first_was_dot_next;
      pending_flags       <= pending_flags_next;
      pending_count       <= pending_count_next;
      committed_flags     <= committed_flags_next;
      committed_count     <= committed_count_next;
      if (q_pop && finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && finish) begin
      res_flags <= fin_flags;
      res_count <= fin_count;
    end
  end

endmodule

// ===== hw/rtl/dns_name_syntax_checker.sv =====
// Top level of the DNS name syntax checker: config registers and stage wiring.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_tvalid / s_tready    s_tdata char_code, s_tuser has_char, s_tlast last
//  m_axis    out  m_tvalid / m_tready    m_tdata problem_flags, problem_count
//  cfg       in   cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// One beat per cycle sustained while m_tready does not hold back results; a name's result is presented
// once its final beat has passed the front register, the queue and the back output register.
// Synchronous reset restores register defaults and clears all name state.
// The queue lets the front keep taking beats while a result waits on m_tready.
`timescale 1ns / 1ps
module dns_name_syntax_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic [0:0]  s_tuser,   // [0] has_char
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [9:0] problem_flags, [17:10] problem_count, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import dnsc_pkg::*;

  dnsc_cfg_t  cfg;
  dnsc_char_t fr_char;
  dnsc_char_t q_data;
  logic       fr_valid;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic [9:0] res_flags;
  logic [7:0] res_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.record_name_mode <= 1'b1;
      cfg.underscore_ok    <= 1'b0;
      cfg.max_name_length  <= 8'd255;
      cfg.max_label_length <= 6'd63;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECORD_MODE: cfg.record_name_mode <= cfg_data[0];
        REG_ALLOW_UNDER: cfg.underscore_ok    <= cfg_data[0];
        REG_MAX_NAME:    cfg.max_name_length  <= cfg_data;
        REG_MAX_LABEL:   cfg.max_label_length <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  dnsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .char_code (s_tdata),
    .has_char  (s_tuser[0]),
    .last      (s_tlast),
    .out_valid (fr_valid),
    .out_ready (!q_full),
    .out_char  (fr_char)
  );

  dnsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fr_valid && !q_full),
    .push_data (fr_char),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  dnsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_flags (res_flags),
    .res_count (res_count)
  );

  assign m_tdata = {6'b0, res_count, res_flags};

endmodule
